@@ rtl/core/asg_pkg.sv @@
// ----------------------------------------------------------------------------
// asg_pkg
// Shared types for the activity selection block: controller commands,
// datapath status and controller state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package asg_pkg;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } asg_state_t;

  typedef struct packed {
    logic load;   // store the accepted activity into the chain
    logic step;   // examine chain head and shift the chain
    logic flush;  // emit pending selection as final, clear the set
  } asg_cmd_t;

  typedef struct packed {
    logic out_free;    // result register can take a request this cycle
    logic scan_empty;  // no activities left in the chain
  } asg_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/asg_if.sv @@
// ----------------------------------------------------------------------------
// asg_in_if / asg_out_if
// Valid/ready channels for activity requests and selection results.
// ----------------------------------------------------------------------------
`default_nettype none

interface asg_in_if #(parameter int TW = 16);
  logic          valid;
  logic          ready;
  logic [TW-1:0] start_time;
  logic [TW-1:0] end_time;
  logic          last_item;
  modport source (output valid, start_time, end_time, last_item, input ready);
  modport sink   (input valid, start_time, end_time, last_item, output ready);
endinterface

interface asg_out_if #(parameter int TW = 16);
  logic          valid;
  logic          ready;
  logic [5:0]    activity_number;
  logic [TW-1:0] current_time;
  logic [5:0]    selected_count;
  logic          final_result;
  logic          overflowed;
  modport source (output valid, activity_number, current_time, selected_count,
                  final_result, overflowed, input ready);
  modport sink   (input valid, activity_number, current_time, selected_count,
                  final_result, overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/activity_selection_greedy.sv @@
// Loading stores accepted requests into the chain at 1 request per cycle.
// After the last request the scan steps once per stored activity, then flushes
// (one chain shift per cycle), pausing only while the result side stalls.
// Results leave through a one-entry output register; the final result shows
// in the cycle after the scan ends. rst_n is synchronous, active low, and clears
// the stored set, counters and valid flags; cell contents are not reset.
// ----------------------------------------------------------------------------
// activity_selection_greedy
// Greedy interval scheduling: sorted insertion chain plus a greedy scan.
// ----------------------------------------------------------------------------
`default_nettype none

module activity_selection_greedy #(
  parameter int MAX_ACTIVITIES = 32,
  parameter int TIME_WIDTH     = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  asg_in_if.sink   in_req,
  asg_out_if.source out_res
);
  import asg_pkg::*;

  asg_cmd_t cmd;
  asg_sts_t sts;

  // sequencer: loading accepts a request every cycle, then scan runs alone
  asg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_last  (in_req.last_item),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // chain of cells kept in (end, start, arrival) order; head is scanned
  asg_dp #(
    .MAX_ACTIVITIES (MAX_ACTIVITIES),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_start   (in_req.start_time),
    .in_end     (in_req.end_time),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_number (out_res.activity_number),
    .out_time   (out_res.current_time),
    .out_count  (out_res.selected_count),
    .out_final  (out_res.final_result),
    .out_ovf    (out_res.overflowed)
  );

endmodule

`default_nettype wire

@@ rtl/core/asg_ctrl.sv @@
// ----------------------------------------------------------------------------
// asg_ctrl
// Load / scan sequencer. Issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire asg_pkg::asg_sts_t sts,
  output asg_pkg::asg_cmd_t      cmd
);
  import asg_pkg::*;

  asg_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.out_free) begin
          if (sts.scan_empty) begin
            cmd.flush = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/asg_dp.sv @@
// ----------------------------------------------------------------------------
// asg_dp
// Sorted insertion chain, greedy scan registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_dp #(
  parameter int MAX_ACTIVITIES = 32,
  parameter int TIME_WIDTH     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire asg_pkg::asg_cmd_t     cmd,
  output asg_pkg::asg_sts_t          sts,
  input  wire logic [TIME_WIDTH-1:0] in_start,
  input  wire logic [TIME_WIDTH-1:0] in_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [5:0]                 out_number,
  output logic [TIME_WIDTH-1:0]      out_time,
  output logic [5:0]                 out_count,
  output logic                       out_final,
  output logic                       out_ovf
);
  import asg_pkg::*;

  localparam int CW = $clog2(MAX_ACTIVITIES + 1);
  localparam int TW = TIME_WIDTH;

  // chain cells, kept sorted by (end, start, number)
  logic [TW-1:0] st_r  [MAX_ACTIVITIES];
  logic [TW-1:0] en_r  [MAX_ACTIVITIES];
  logic [CW-1:0] num_r [MAX_ACTIVITIES];

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [TW-1:0] free_r;
  logic [CW-1:0] pick_r;

  logic          pend_v_r;
  logic [CW-1:0] pend_num_r;
  logic [TW-1:0] pend_time_r;
  logic [CW-1:0] pend_cnt_r;

  logic          out_v_r;
  logic [CW-1:0] out_num_r;
  logic [TW-1:0] out_time_r;
  logic [CW-1:0] out_cnt_r;
  logic          out_fin_r;
  logic          out_ovf_r;

  logic [MAX_ACTIVITIES-1:0] less;
  logic                      full;
  logic                      sel;
  logic                      emit;
  logic                      emit_fin;

  assign full = (count_r == CW'(MAX_ACTIVITIES));
  assign sel  = (st_r[0] >= free_r);

  // new key sorts ahead of cell i; equal times keep arrival order
  always_comb begin
    for (int i = 0; i < MAX_ACTIVITIES; i++) begin
      less[i] = (in_end < en_r[i]) || ((in_end == en_r[i]) && (in_start < st_r[i]));
    end
  end

  assign sts.out_free   = !out_v_r || out_ready;
  assign sts.scan_empty = (count_r == '0);

  assign emit     = cmd.flush || (cmd.step && sel && pend_v_r);
  assign emit_fin = cmd.flush;

  // chain: insert while loading, shift toward head while scanning
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ACTIVITIES; i++) begin
      if (cmd.load && !full) begin
        if ((CW'(i) == count_r || (CW'(i) < count_r && less[i])) &&
            (i == 0 || !less[(i == 0) ? 0 : i-1])) begin
          st_r[i]  <= in_start;
          en_r[i]  <= in_end;
          num_r[i] <= count_r + CW'(1);
        end else if (i > 0 && CW'(i) <= count_r && less[(i == 0) ? 0 : i-1]) begin
          st_r[i]  <= st_r[(i == 0) ? 0 : i-1];
          en_r[i]  <= en_r[(i == 0) ? 0 : i-1];
          num_r[i] <= num_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.step && i < MAX_ACTIVITIES-1) begin
        st_r[i]  <= st_r[(i < MAX_ACTIVITIES-1) ? i+1 : i];
        en_r[i]  <= en_r[(i < MAX_ACTIVITIES-1) ? i+1 : i];
        num_r[i] <= num_r[(i < MAX_ACTIVITIES-1) ? i+1 : i];
      end
    end
  end

  // control and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      free_r   <= '0;
      pick_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) ovf_r   <= 1'b1;
        else      count_r <= count_r + CW'(1);
      end
      if (cmd.step) begin
        count_r <= count_r - CW'(1);
        if (sel) begin
          free_r   <= en_r[0];
          pick_r   <= pick_r + CW'(1);
          pend_v_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        count_r  <= '0;
        ovf_r    <= 1'b0;
        free_r   <= '0;
        pick_r   <= '0;
        pend_v_r <= 1'b0;
      end
      if (emit)           out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step && sel) begin
      pend_num_r  <= num_r[0];
      pend_time_r <= en_r[0];
      pend_cnt_r  <= pick_r + CW'(1);
    end
    if (emit) begin
      out_num_r  <= pend_num_r;
      out_time_r <= pend_time_r;
      out_cnt_r  <= pend_cnt_r;
      out_fin_r  <= emit_fin;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_number = 6'(out_num_r);
  assign out_time   = out_time_r;
  assign out_count  = 6'(out_cnt_r);
  assign out_final  = out_fin_r;
  assign out_ovf    = out_ovf_r;

endmodule

`default_nettype wire

@@ rtl/core/asg_checker.sv @@
// ----------------------------------------------------------------------------
// asg_checker
// Port-level checks for the activity selection block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_checker #(
  parameter int TW = 16
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          in_last,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [5:0]    out_number,
  input wire logic [TW-1:0] out_time,
  input wire logic [5:0]    out_count
);

  // stalled result request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_number) && $stable(out_time)
                                && $stable(out_count))
    else $error("result payload changed under stall");

  // arrival numbers are one-based
  a_num_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_number != 6'd0)
    else $error("zero activity number");

  // every result counts at least one selection
  a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count != 6'd0)
    else $error("zero selection count");

  // last request starts a scan, which blocks new requests
  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request taken right after last item");

endmodule

bind activity_selection_greedy asg_checker #(.TW(TIME_WIDTH)) u_asg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_last    (in_req.last_item),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_number (out_res.activity_number),
  .out_time   (out_res.current_time),
  .out_count  (out_res.selected_count)
);

`default_nettype wire

@@ tb/tb_pkg.sv @@
// ----------------------------------------------------------------------------
// tb_pkg
// Request and result records used by the activity selection testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_pkg;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic        last_item;
  } act_req_t;

  typedef struct packed {
    logic [5:0]  activity_number;
    logic [15:0] current_time;
    logic [5:0]  selected_count;
    logic        final_result;
    logic        overflowed;
  } pick_t;

endpackage

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives sets of activities into activity_selection_greedy and checks each
// greedy selection against an in-bench schedule predictor, under random
// valid/ready gaps on both channels except in a final gap-free phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tb_pkg::*;

  localparam int CAP = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  asg_in_if  #(16) req_ch ();
  asg_out_if #(16) res_ch ();

  activity_selection_greedy dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_res(res_ch.source)
  );

  // pending requests, expected selections
  act_req_t req_q[$];
  pick_t    pick_q[$];

  // predictor state: the activity set being loaded
  logic [15:0] set_start[CAP];
  logic [15:0] set_end[CAP];
  int          set_len = 0;
  bit          set_dropped = 0;

  int  errors = 0;
  int  req_sent = 0;
  int  picks_seen = 0;
  int  sets_run = 0;
  int  send_idle = 29;
  int  recv_idle = 47;
  bit  stim_done = 0;
  bit  in_fire = 0;

  // Store the activity; on the last one, order by (end, start, number) and
  // scan greedily, queueing one expected result per selection.
  task automatic schedule_request(input act_req_t r);
    int          ord[CAP];
    int          n, k, j, t, picks;
    logic [15:0] free_t;
    pick_t       p;
    if (set_len < CAP) begin
      set_start[set_len] = r.start_time;
      set_end[set_len]   = r.end_time;
      set_len++;
    end else begin
      set_dropped = 1;
    end
    if (!r.last_item) return;
    n = set_len;
    for (k = 0; k < n; k++) ord[k] = k;
    for (k = 1; k < n; k++) begin
      t = ord[k];
      j = k;
      while (j > 0 && (set_end[t] < set_end[ord[j-1]] ||
             (set_end[t] == set_end[ord[j-1]] && set_start[t] < set_start[ord[j-1]]))) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = t;
    end
    free_t = 0;
    picks  = 0;
    for (k = 0; k < n; k++) begin
      t = ord[k];
      if (set_start[t] >= free_t) begin
        free_t = set_end[t];
        picks++;
        p.activity_number = 6'(t + 1);
        p.current_time    = free_t;
        p.selected_count  = 6'(picks);
        p.final_result    = 1'b0;
        p.overflowed      = set_dropped;
        pick_q = {pick_q, p};
      end
    end
    pick_q[pick_q.size()-1].final_result = 1'b1;
    set_len = 0;
    set_dropped = 0;
    sets_run++;
  endtask

  // Driver: new request presented at the falling edge after acceptance.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || in_fire) begin
      // previous request (if any) was accepted at the last rising edge
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        req_ch.valid      <= 1'b1;
        req_ch.start_time <= req_q[0].start_time;
        req_ch.end_time   <= req_q[0].end_time;
        req_ch.last_item  <= req_q[0].last_item;
        req_q.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    pick_t got, exp_p;
    in_fire = rst_n && req_ch.valid && req_ch.ready;
    if (in_fire) begin
      schedule_request({req_ch.start_time, req_ch.end_time, req_ch.last_item});
      req_sent++;
    end
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = {res_ch.activity_number, res_ch.current_time, res_ch.selected_count,
             res_ch.final_result, res_ch.overflowed};
      picks_seen++;
      if (pick_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_p = pick_q.pop_front();
        if (got !== exp_p) begin
          $display("%0t: mismatch expected num=%0d t=%0d cnt=%0d fin=%0b ovf=%0b",
                   $time, exp_p.activity_number, exp_p.current_time,
                   exp_p.selected_count, exp_p.final_result, exp_p.overflowed);
          $display("%0t:          actual   num=%0d t=%0d cnt=%0d fin=%0b ovf=%0b",
                   $time, got.activity_number, got.current_time,
                   got.selected_count, got.final_result, got.overflowed);
          errors++;
        end
      end
    end
  end

  function automatic logic [15:0] rand_time(input int mode);
    case (mode)
      0:       rand_time = 16'($urandom_range(0, 40));
      1:       rand_time = 16'($urandom_range(65495, 65535));
      default: rand_time = 16'($urandom);
    endcase
  endfunction

  // queue one set of n activities; times drawn from a small, a top-end or the full range
  task automatic add_set(input int n, input int mode);
    act_req_t r;
    int       k;
    for (k = 0; k < n; k++) begin
      r.start_time = rand_time(mode);
      r.end_time   = (mode == 0 && $urandom_range(9) != 0) ?
                     r.start_time + 16'($urandom_range(0, 12)) : rand_time(mode);
      r.last_item  = (k == n - 1);
      req_q = {req_q, r};
    end
  endtask

  task automatic add_req(input logic [15:0] s, input logic [15:0] e, input logic l);
    act_req_t r;
    r.start_time = s;
    r.end_time   = e;
    r.last_item  = l;
    req_q = {req_q, r};
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || req_ch.valid || pick_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int phase, total;
    req_ch.valid = 1'b0;
    req_ch.start_time = '0;
    req_ch.end_time = '0;
    req_ch.last_item = 1'b0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: single activity, extremes, ties, end before start
    add_req(16'd0, 16'd0, 1'b1);
    add_req(16'hFFFF, 16'hFFFF, 1'b1);
    add_req(16'd5, 16'd10, 1'b0);
    add_req(16'd5, 16'd10, 1'b0);   // exact tie, arrival order decides
    add_req(16'd10, 16'd10, 1'b0);  // starts right at free time
    add_req(16'd9, 16'd3, 1'b0);    // end before start
    add_req(16'hFFFF, 16'h0000, 1'b0);
    add_req(16'h0000, 16'hFFFF, 1'b1);
    add_req(16'hAAAA, 16'h5555, 1'b0);
    add_req(16'h5555, 16'hAAAA, 1'b1);
    // a full store and then some: overflow, dropped last item still runs
    add_set(CAP + 3, 2);
    wait_drained();

    // random part over three idling phases
    total = 0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 29 : (phase == 1) ? 47 : 0;
      recv_idle = (phase == 0) ? 47 : (phase == 1) ? 29 : 0;
      while (total < 72 * (phase + 1)) begin
        int n, mode;
        case ($urandom_range(9))
          0:       n = $urandom_range(CAP + 1, CAP + 4);
          1:       n = CAP;
          default: n = $urandom_range(1, 10);
        endcase
        mode = $urandom_range(2);
        add_set(n, mode);
        total += n;
      end
      wait_drained();
    end

    stim_done = 1;
    $display("covered %0d requests in %0d sets, %0d selections checked",
             req_sent, sets_run, picks_seen);
    if (errors == 0 && pick_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout, %0d results outstanding", pick_q.size());
    $display("tb failed");
    $finish;
  end

endmodule
